// ===== sv/tmm_pkg.sv =====
// Package for the tiled matrix multiply engine: dimensions, widths, codes and payload types.
package tmm_pkg;

    // Tile dimensions
    localparam int ROWS  = 16;
    localparam int COLS  = 16;
    localparam int INNER = 16;

    // Index and address widths derived from the dimensions
    localparam int ROW_W = (ROWS  > 1) ? $clog2(ROWS)  : 1;
    localparam int COL_W = (COLS  > 1) ? $clog2(COLS)  : 1;
    localparam int INN_W = (INNER > 1) ? $clog2(INNER) : 1;
    localparam int A_DEPTH = ROWS * INNER;
    localparam int B_DEPTH = INNER * COLS;
    localparam int C_DEPTH = ROWS * COLS;
    localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    // Payload widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_C  = 2'd3;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [OP_W-1:0]          op_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

// ===== sv/tmm_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface tmm_req_if;
    logic              valid;
    logic              ready;
    tmm_pkg::op_t      op;
    tmm_pkg::idx_t     row;
    tmm_pkg::idx_t     col;
    tmm_pkg::elem_t    value;

    modport source (output valid, output op, output row, output col, output value, input ready);
    modport sink   (input valid, input op, input row, input col, input value, output ready);
endinterface

interface tmm_rsp_if;
    logic              valid;
    logic              ready;
    logic              kind;
    tmm_pkg::acc_t     product;

    modport source (output valid, output kind, output product, input ready);
    modport sink   (input valid, input kind, input product, output ready);
endinterface

// ===== sv/tiled_matrix_multiply_engine_core.sv =====
// Top level of the tiled matrix multiply engine: stores, MAC sequencer and output register.
//
// Usage:
//   req (sink): one transaction per item. op selects load A element, load B element,
//     compute tile or read C element; row/col index the element, value is Q1.15.
//   rsp (source): kind 0 carries a C element (Q10.30 sum, 40 bits); kind 1 marks the
//     end of a compute, with product zero. Loads produce no response.
// Timing:
//   Loads are taken one per cycle while idle. A read returns its data through the
//   output register: the C memory is read at the accepting edge, and the output
//   register loads it once the output slot is free. For a compute, a single
//   multiply-accumulate unit walks i, j, k, fed by one read port on each of the A
//   and B memories; the done response follows once the MAC pipeline has drained.
//   No new item is taken while a compute or read is in flight.
// Reset: clears the sequencer and output valid; the A, B and C memories are not
//   cleared, so elements must be written (or computed) before they are used.
// Stall: a response waiting on rsp.ready is held in the output register; loads are
//   still accepted meanwhile, and the next compute or read waits for the slot.
module tiled_matrix_multiply_engine_core (
    input  logic           clk,
    input  logic           rst_n,
    tmm_req_if.sink        req,
    tmm_rsp_if.source      rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_RD    = 2'd3;

    // Memories
    tmm_pkg::elem_t a_mem [tmm_pkg::A_DEPTH];
    tmm_pkg::elem_t b_mem [tmm_pkg::B_DEPTH];
    tmm_pkg::acc_t  c_mem [tmm_pkg::C_DEPTH];

    logic [1:0]              state_reg, state_next;
    logic [tmm_pkg::ROW_W-1:0] i_reg, i_next;
    logic [tmm_pkg::COL_W-1:0] j_reg, j_next;
    logic [tmm_pkg::INN_W-1:0] k_reg, k_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    tmm_pkg::acc_t           out_prod_reg, out_prod_next;

    // MAC pipeline
    logic                    s1_v_reg, s1_first_reg, s1_last_reg;
    logic [tmm_pkg::C_AW-1:0] s1_caddr_reg;
    tmm_pkg::elem_t          a_rd_reg, b_rd_reg;
    logic                    s2_v_reg, s2_first_reg, s2_last_reg;
    logic [tmm_pkg::C_AW-1:0] s2_caddr_reg;
    tmm_pkg::prod_t          prod_reg;
    tmm_pkg::acc_t           acc_reg, acc_next;

    // Read path
    tmm_pkg::acc_t           c_rd_reg;
    logic                    rd_oor_reg;

    logic                    accept, out_free, issue;
    logic                    row_ok_a, col_ok_a, row_ok_b, col_ok_b, row_ok_c, col_ok_c;
    logic                    i_last, j_last, k_last;
    logic [tmm_pkg::A_AW-1:0] a_waddr, a_raddr;
    logic [tmm_pkg::B_AW-1:0] b_waddr, b_raddr;
    logic [tmm_pkg::C_AW-1:0] c_raddr, c_iaddr;

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign issue       = (state_reg == S_CMP);

    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.product = out_prod_reg;

    // Range checks on request indexes
    assign row_ok_a = 32'(req.row) < tmm_pkg::ROWS;
    assign col_ok_a = 32'(req.col) < tmm_pkg::INNER;
    assign row_ok_b = 32'(req.row) < tmm_pkg::INNER;
    assign col_ok_b = 32'(req.col) < tmm_pkg::COLS;
    assign row_ok_c = 32'(req.row) < tmm_pkg::ROWS;
    assign col_ok_c = 32'(req.col) < tmm_pkg::COLS;

    // Address generation (row-major)
    assign a_waddr = tmm_pkg::A_AW'(32'(req.row) * tmm_pkg::INNER + 32'(req.col));
    assign b_waddr = tmm_pkg::B_AW'(32'(req.row) * tmm_pkg::COLS + 32'(req.col));
    assign c_raddr = tmm_pkg::C_AW'(32'(req.row) * tmm_pkg::COLS + 32'(req.col));
    assign a_raddr = tmm_pkg::A_AW'(32'(i_reg) * tmm_pkg::INNER + 32'(k_reg));
    assign b_raddr = tmm_pkg::B_AW'(32'(k_reg) * tmm_pkg::COLS + 32'(j_reg));
    assign c_iaddr = tmm_pkg::C_AW'(32'(i_reg) * tmm_pkg::COLS + 32'(j_reg));

    assign i_last = (32'(i_reg) == tmm_pkg::ROWS - 1);
    assign j_last = (32'(j_reg) == tmm_pkg::COLS - 1);
    assign k_last = (32'(k_reg) == tmm_pkg::INNER - 1);

    // A store: written by loads, read by the sequencer
    always_ff @(posedge clk)
    begin
        if (accept && req.op == tmm_pkg::OP_LOAD_A && row_ok_a && col_ok_a)
        begin
            a_mem[a_waddr] <= req.value;
        end
        a_rd_reg <= a_mem[a_raddr];
    end

    // B store
    always_ff @(posedge clk)
    begin
        if (accept && req.op == tmm_pkg::OP_LOAD_B && row_ok_b && col_ok_b)
        begin
            b_mem[b_waddr] <= req.value;
        end
        b_rd_reg <= b_mem[b_raddr];
    end

    // Accumulate; the last term of a dot product is written straight to C
    assign acc_next = (s2_first_reg ? '0 : acc_reg) + tmm_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_v_reg && s2_last_reg)
        begin
            c_mem[s2_caddr_reg] <= acc_next;
        end
        if (accept && req.op == tmm_pkg::OP_READ_C)
        begin
            c_rd_reg <= c_mem[c_raddr];
        end
    end

    // MAC pipeline payload
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= k_last;
        s1_caddr_reg <= c_iaddr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_caddr_reg <= s1_caddr_reg;
        prod_reg     <= a_rd_reg * b_rd_reg;
        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
        if (accept)
        begin
            rd_oor_reg <= !(row_ok_c && col_ok_c);
        end
    end

    // MAC pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_prod_next  = out_prod_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == tmm_pkg::OP_COMPUTE)
                begin
                    state_next = S_CMP;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
                else if (accept && req.op == tmm_pkg::OP_READ_C)
                begin
                    state_next = S_RD;
                end
            end
            S_CMP:
            begin
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            i_next     = '0;
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tmm_pkg::KIND_DONE;
                    out_prod_next  = '0;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tmm_pkg::KIND_DATA;
                    out_prod_next  = rd_oor_reg ? '0 : c_rd_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_prod_reg <= out_prod_next;
    end

    // Checks
    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && state_next == S_IDLE) |-> (!s1_v_reg && !s2_v_reg))
        else $error("compute done raised with MAC pipeline still busy");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == tmm_pkg::KIND_DONE) |-> (rsp.product == '0))
        else $error("done response carries nonzero product");

    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == tmm_pkg::OP_COMPUTE || req.op == tmm_pkg::OP_READ_C))
        |=> !req.ready)
        else $error("new request accepted behind a compute or read");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> (s2_v_reg || s1_first_reg))
        else $error("dot product started without its first term");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the tiled matrix multiply engine: directed table, random load/compute/read traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int  ITEM_TARGET = 1750;
    localparam int  QUIET_ITEMS = 150;
    localparam int  LONG_HOLD   = 300;
    localparam int  MAX_RAND_COMPUTES = 16;

    localparam tmm_pkg::elem_t Q_MIN = 16'sh8000;
    localparam tmm_pkg::elem_t Q_MAX = 16'sh7fff;
    // 16 terms of (-1.0 * -1.0) in Q10.30
    localparam tmm_pkg::acc_t ALL_MIN_SQ = 40'sd17179869184;

    typedef struct packed {
        logic           kind;
        tmm_pkg::acc_t  product;
    } result_t;

    typedef struct packed {
        tmm_pkg::op_t   op;
        tmm_pkg::idx_t  row;
        tmm_pkg::idx_t  col;
        tmm_pkg::elem_t value;
        logic           typed;
        logic           kind;
        tmm_pkg::acc_t  product;
    } stim_row_t;

    // Directed rows; typed rows carry their own expected result
    stim_row_t directed_rows [0:15] = '{
        '{tmm_pkg::OP_COMPUTE, 4'd0,  4'd0,  16'sd0,  1'b1, tmm_pkg::KIND_DONE, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd0,  4'd0,  16'sd0,  1'b1, tmm_pkg::KIND_DATA, ALL_MIN_SQ},
        '{tmm_pkg::OP_READ_C,  4'd15, 4'd15, 16'sd0,  1'b1, tmm_pkg::KIND_DATA, ALL_MIN_SQ},
        '{tmm_pkg::OP_READ_C,  4'd5,  4'd10, 16'sd0,  1'b1, tmm_pkg::KIND_DATA, ALL_MIN_SQ},
        '{tmm_pkg::OP_LOAD_A,  4'd0,  4'd0,  Q_MAX,   1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_LOAD_A,  4'd0,  4'd15, 16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_LOAD_A,  4'd15, 4'd15, 16'sd1,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_LOAD_B,  4'd0,  4'd0,  -16'sd1, 1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_LOAD_B,  4'd15, 4'd15, Q_MAX,   1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_LOAD_B,  4'd15, 4'd0,  Q_MIN,   1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_COMPUTE, 4'd0,  4'd0,  16'sd0,  1'b1, tmm_pkg::KIND_DONE, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd0,  4'd0,  16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd15, 4'd15, 16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd0,  4'd15, 16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd15, 4'd0,  16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0},
        '{tmm_pkg::OP_READ_C,  4'd10, 4'd5,  16'sd0,  1'b0, tmm_pkg::KIND_DATA, 40'sd0}
    };

    logic clk;
    logic rst_n;

    tmm_req_if req_ch ();
    tmm_rsp_if rsp_ch ();

    // Typed expectation travels alongside the request fields
    logic           tag_typed;
    logic           tag_kind;
    tmm_pkg::acc_t  tag_product;

    logic  quiet;
    logic  hold_req;

    // Predictor copy of the tile stores
    tmm_pkg::elem_t a_tile [0:tmm_pkg::A_DEPTH-1];
    tmm_pkg::elem_t b_tile [0:tmm_pkg::B_DEPTH-1];
    tmm_pkg::acc_t  c_tile [0:tmm_pkg::C_DEPTH-1];

    result_t pending_results [$];

    int errors;
    int items_sent;
    int reads_checked;
    int computes_checked;

    tiled_matrix_multiply_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Tile engine behavior: updates the stores, returns 1 when a result is due
    function automatic bit tile_step(input tmm_pkg::op_t op, input tmm_pkg::idx_t row,
                                     input tmm_pkg::idx_t col, input tmm_pkg::elem_t value,
                                     output result_t res);
        tmm_pkg::acc_t sum;
        res = '0;
        case (op)
            tmm_pkg::OP_LOAD_A:
            begin
                if (row < tmm_pkg::ROWS && col < tmm_pkg::INNER)
                    a_tile[row * tmm_pkg::INNER + col] = value;
                return 1'b0;
            end
            tmm_pkg::OP_LOAD_B:
            begin
                if (row < tmm_pkg::INNER && col < tmm_pkg::COLS)
                    b_tile[row * tmm_pkg::COLS + col] = value;
                return 1'b0;
            end
            tmm_pkg::OP_COMPUTE:
            begin
                for (int i = 0; i < tmm_pkg::ROWS; i++)
                    for (int j = 0; j < tmm_pkg::COLS; j++)
                    begin
                        sum = '0;
                        for (int k = 0; k < tmm_pkg::INNER; k++)
                            sum = sum + tmm_pkg::acc_t'(a_tile[i * tmm_pkg::INNER + k]) *
                                        tmm_pkg::acc_t'(b_tile[k * tmm_pkg::COLS + j]);
                        c_tile[i * tmm_pkg::COLS + j] = sum;
                    end
                res.kind = tmm_pkg::KIND_DONE;
                return 1'b1;
            end
            default:
            begin
                res.kind = tmm_pkg::KIND_DATA;
                if (row < tmm_pkg::ROWS && col < tmm_pkg::COLS)
                    res.product = c_tile[row * tmm_pkg::COLS + col];
                return 1'b1;
            end
        endcase
    endfunction

    // Predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.kind    = rsp_ch.kind;
                got.product = rsp_ch.product;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected response: kind %0d product %0d", got.kind, got.product);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.product !== want.product)
                    begin
                        $error("product: expected %0d, got %0d", want.product, got.product);
                        errors++;
                    end
                    if (want.kind == tmm_pkg::KIND_DONE)
                        computes_checked++;
                    else
                        reads_checked++;
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                if (tile_step(req_ch.op, req_ch.row, req_ch.col, req_ch.value, predicted))
                begin
                    if (tag_typed)
                    begin
                        predicted.kind    = tag_kind;
                        predicted.product = tag_product;
                    end
                    pending_results.push_back(predicted);
                end
            end
        end
    end

    // Response side: random stall bursts plus one long hold-off
    initial
    begin : rsp_stall
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Offer one request and wait for its transaction; may idle afterwards
    task automatic send_item(input tmm_pkg::op_t op, input tmm_pkg::idx_t row,
                             input tmm_pkg::idx_t col, input tmm_pkg::elem_t value,
                             input logic typed = 1'b0,
                             input logic kind = tmm_pkg::KIND_DATA,
                             input tmm_pkg::acc_t product = '0);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.row   <= row;
        req_ch.col   <= col;
        req_ch.value <= value;
        tag_typed    <= typed;
        tag_kind     <= kind;
        tag_product  <= product;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Element values biased toward the Q1.15 extremes
    function automatic tmm_pkg::elem_t pick_value();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return tmm_pkg::elem_t'($urandom);
        endcase
    endfunction

    // Stimulus
    initial
    begin : stimulus
        int             pick;
        int             rand_computes;
        tmm_pkg::idx_t  line;
        tmm_pkg::elem_t fill;
        errors           = 0;
        items_sent       = 0;
        reads_checked    = 0;
        computes_checked = 0;
        rand_computes    = 0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= tmm_pkg::OP_LOAD_A;
        req_ch.row   <= '0;
        req_ch.col   <= '0;
        req_ch.value <= '0;
        tag_typed    <= 1'b0;
        tag_kind     <= tmm_pkg::KIND_DATA;
        tag_product  <= '0;
        quiet        <= 1'b0;
        hold_req     <= 1'b0;
        wait (rst_n);
        @(posedge clk);

        // Fill both operand tiles with -1.0 so every entry is defined
        for (int i = 0; i < tmm_pkg::ROWS; i++)
            for (int k = 0; k < tmm_pkg::INNER; k++)
                send_item(tmm_pkg::OP_LOAD_A, tmm_pkg::idx_t'(i), tmm_pkg::idx_t'(k), Q_MIN);
        for (int k = 0; k < tmm_pkg::INNER; k++)
            for (int j = 0; j < tmm_pkg::COLS; j++)
                send_item(tmm_pkg::OP_LOAD_B, tmm_pkg::idx_t'(k), tmm_pkg::idx_t'(j), Q_MIN);

        // Directed table
        foreach (directed_rows[n])
            send_item(directed_rows[n].op, directed_rows[n].row, directed_rows[n].col,
                      directed_rows[n].value, directed_rows[n].typed,
                      directed_rows[n].kind, directed_rows[n].product);

        // Random traffic; receiver holds off for a long stretch at the start
        hold_req <= 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
                quiet <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick == 0 && rand_computes < MAX_RAND_COMPUTES)
            begin
                rand_computes++;
                send_item(tmm_pkg::OP_COMPUTE, tmm_pkg::idx_t'($urandom),
                          tmm_pkg::idx_t'($urandom), tmm_pkg::elem_t'($urandom));
            end
            else if (pick < 35)
                send_item(tmm_pkg::OP_LOAD_A, tmm_pkg::idx_t'($urandom),
                          tmm_pkg::idx_t'($urandom), pick_value());
            else if (pick < 70)
                send_item(tmm_pkg::OP_LOAD_B, tmm_pkg::idx_t'($urandom),
                          tmm_pkg::idx_t'($urandom), pick_value());
            else if (pick < 74)
            begin
                // Sweep a whole A row or B column with one extreme value
                line = tmm_pkg::idx_t'($urandom);
                fill = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
                for (int k = 0; k < tmm_pkg::INNER; k++)
                    if (pick < 72)
                        send_item(tmm_pkg::OP_LOAD_A, line, tmm_pkg::idx_t'(k), fill);
                    else
                        send_item(tmm_pkg::OP_LOAD_B, tmm_pkg::idx_t'(k), line, fill);
            end
            else
                send_item(tmm_pkg::OP_READ_C, tmm_pkg::idx_t'($urandom),
                          tmm_pkg::idx_t'($urandom), tmm_pkg::elem_t'($urandom));
        end
        req_ch.valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests; checked %0d C reads and %0d compute completions.",
                 items_sent, reads_checked, computes_checked);
        $display("Mismatches or unexpected responses: %0d.", errors);
        if (errors == 0)
            $display("tiled_matrix_multiply_engine_core test passed");
        else
            $display("tiled_matrix_multiply_engine_core test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("tiled_matrix_multiply_engine_core test failed");
        $finish;
    end

endmodule

// ===== tiled_matrix_multiply_engine_core.f =====
sv/tmm_pkg.sv
sv/tmm_if.sv
sv/tiled_matrix_multiply_engine_core.sv
tb/sv/testbench.sv
